>>> src/bpds_pkg.sv
// Shared types, widths and constants for the button press duration statistics block.
// No dependencies; every module of the block imports this package.
package bpds_pkg;

   // Timebase and statistics widths
   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int SUM_WIDTH   = 32;

   // Result field widths
   localparam int PRESS_WIDTH = 32;
   localparam int FIELD_WIDTH = 16;
   localparam int AVG_WIDTH   = 32;

   localparam int RSP_FIELDS_WIDTH = PRESS_WIDTH + 1 + 3 * FIELD_WIDTH + AVG_WIDTH;
   localparam int RSP_DATA_WIDTH   = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH    = RSP_DATA_WIDTH - RSP_FIELDS_WIDTH;
   localparam int REQ_DATA_WIDTH   = 8;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int LONG_WIDTH      = 16;
   localparam int INTERVAL_WIDTH  = 12;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_MS     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPORT_INTERVAL_S = 1'b1;

   localparam int unsigned MS_PER_S       = 1000;
   localparam int unsigned LONG_RESET     = 500;
   localparam int unsigned INTERVAL_RESET = 10;
   localparam int THR_WIDTH = INTERVAL_WIDTH + $clog2(MS_PER_S);

   // Result kinds
   localparam logic KIND_PRESS  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                  press;
      logic                  report;
      logic                  is_long;
      logic [TIME_WIDTH-1:0] dur;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Clamp to a 16-bit result field
   function automatic logic [FIELD_WIDTH-1:0] sat_field(input logic [63:0] v);
      return (v > 64'hFFFF) ? '1 : v[FIELD_WIDTH-1:0];
   endfunction

   // Clamp to a 32-bit word
   function automatic logic [SUM_WIDTH-1:0] sat_word(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? '1 : v[SUM_WIDTH-1:0];
   endfunction

endpackage

>>> src/bpds_front.sv
// Front part: takes ticks, keeps the millisecond clock and edge state, holds the
// configuration registers and pushes press/report commands. Depends on bpds_pkg.
module bpds_front import bpds_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] button_up
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  q_status_type               q_status,
   output logic                       q_push,
   output cmd_type                    q_push_cmd
);

   logic                  prev_level_ff, prev_level_in;
   logic [TIME_WIDTH-1:0] now_ms_ff, now_ms_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TIME_WIDTH-1:0] last_report_ff, last_report_in;
   logic [LONG_WIDTH-1:0] long_ms_ff, long_ms_in;
   logic [THR_WIDTH-1:0]  report_thr_ff, report_thr_in;

   logic                  accept;
   logic                  level;
   logic                  rise;
   logic                  fall;
   logic [TIME_WIDTH-1:0] dur;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  report_due;
   logic                  is_long;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];
   assign rise       = level && !prev_level_ff;
   assign fall       = !level && prev_level_ff;
   assign dur        = now_ms_ff - press_start_ff;
   assign elapsed    = now_ms_ff - last_report_ff;
   // interval in ms is kept premultiplied, so whole seconds compare as ms
   assign report_due = 64'(elapsed) >= 64'(report_thr_ff);
   assign is_long    = 64'(dur) >= 64'(long_ms_ff);

   assign q_push             = accept && (rise || report_due);
   assign q_push_cmd.press   = rise;
   assign q_push_cmd.report  = report_due;
   assign q_push_cmd.is_long = is_long;
   assign q_push_cmd.dur     = dur;

   always_comb begin
      prev_level_in  = prev_level_ff;
      now_ms_in      = now_ms_ff;
      press_start_in = press_start_ff;
      last_report_in = last_report_ff;
      long_ms_in     = long_ms_ff;
      report_thr_in  = report_thr_ff;
      if (accept) begin
         prev_level_in = level;
         now_ms_in     = now_ms_ff + TIME_WIDTH'(1);
         if (fall) begin
            press_start_in = now_ms_ff;
         end
         if (report_due) begin
            last_report_in = now_ms_ff;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_LONG_PRESS_MS: begin
               long_ms_in = csr_wdata[LONG_WIDTH-1:0];
            end
            CSR_REPORT_INTERVAL_S: begin
               report_thr_in = THR_WIDTH'(32'(csr_wdata[INTERVAL_WIDTH-1:0]) * MS_PER_S);
            end
            default: begin
               long_ms_in = long_ms_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff  <= 1'b1;
         now_ms_ff      <= '0;
         press_start_ff <= '0;
         last_report_ff <= '0;
         long_ms_ff     <= LONG_WIDTH'(LONG_RESET);
         report_thr_ff  <= THR_WIDTH'(INTERVAL_RESET * MS_PER_S);
      end else begin
         prev_level_ff  <= prev_level_in;
         now_ms_ff      <= now_ms_in;
         press_start_ff <= press_start_in;
         last_report_ff <= last_report_in;
         long_ms_ff     <= long_ms_in;
         report_thr_ff  <= report_thr_in;
      end
   end

endmodule

>>> src/bpds_queue.sv
// Short command queue that decouples the front part from the back part.
// Depends on bpds_pkg for the command type and depth.
module bpds_queue import bpds_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head,
   output q_status_type status
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/bpds_back.sv
// Back part: keeps the press statistics, forms press results, runs the serial
// divider for the average and drives the result register. Depends on bpds_pkg.
module bpds_back import bpds_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   q_head,
   input  q_status_type              q_status,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int DIVIDEND_WIDTH = SUM_WIDTH + 1;
   localparam int DIVISOR_WIDTH  = COUNT_WIDTH + 1;
   localparam int REM_WIDTH      = DIVISOR_WIDTH + 1;
   localparam int STEP_WIDTH     = $clog2(DIVIDEND_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] short_count_ff, short_count_in;
   logic [COUNT_WIDTH-1:0] long_count_ff, long_count_in;
   logic [SUM_WIDTH-1:0]   short_sum_ff, short_sum_in;
   logic [SUM_WIDTH-1:0]   long_sum_ff, long_sum_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [PRESS_WIDTH-1:0]    rsp_press_ff, rsp_press_in;
   logic                      rsp_is_long_ff, rsp_is_long_in;
   logic [FIELD_WIDTH-1:0]    rsp_total_ff, rsp_total_in;
   logic [FIELD_WIDTH-1:0]    rsp_short_ff, rsp_short_in;
   logic [FIELD_WIDTH-1:0]    rsp_long_ff, rsp_long_in;
   logic [AVG_WIDTH-1:0]      rsp_avg_ff, rsp_avg_in;

   logic [FIELD_WIDTH-1:0]    rep_total_ff, rep_total_in;
   logic [FIELD_WIDTH-1:0]    rep_short_ff, rep_short_in;
   logic [FIELD_WIDTH-1:0]    rep_long_ff, rep_long_in;
   logic                      cnt_zero_ff, cnt_zero_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [REM_WIDTH-1:0]      rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;

   logic                      out_free;
   logic [63:0]               dur_ext;
   logic [SUM_WIDTH-1:0]      dur_sat;
   logic [SUM_WIDTH:0]        short_acc;
   logic [SUM_WIDTH:0]        long_acc;
   logic [DIVISOR_WIDTH-1:0]  cnt_all;
   logic [COUNT_WIDTH-1:0]    cnt_sat;
   logic [DIVIDEND_WIDTH-1:0] sum_all;
   logic [REM_WIDTH-1:0]      rem_sh;
   logic [DIVIDEND_WIDTH-1:0] quo_sh;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign dur_ext   = 64'(q_head.dur);
   assign dur_sat   = sat_word(dur_ext);
   assign short_acc = {1'b0, short_sum_ff} + {1'b0, dur_sat};
   assign long_acc  = {1'b0, long_sum_ff} + {1'b0, dur_sat};
   assign cnt_all   = {1'b0, short_count_ff} + {1'b0, long_count_ff};
   assign cnt_sat   = cnt_all[COUNT_WIDTH] ? '1 : cnt_all[COUNT_WIDTH-1:0];
   assign sum_all   = {1'b0, short_sum_ff} + {1'b0, long_sum_ff};
   assign rem_sh    = {rem_ff[REM_WIDTH-2:0], quo_ff[DIVIDEND_WIDTH-1]};
   assign quo_sh    = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b0};

   always_comb begin
      state_in       = state_ff;
      q_pop          = 1'b0;
      short_count_in = short_count_ff;
      long_count_in  = long_count_ff;
      short_sum_in   = short_sum_ff;
      long_sum_in    = long_sum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_press_in   = rsp_press_ff;
      rsp_is_long_in = rsp_is_long_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_short_in   = rsp_short_ff;
      rsp_long_in    = rsp_long_ff;
      rsp_avg_in     = rsp_avg_ff;
      rep_total_in   = rep_total_ff;
      rep_short_in   = rep_short_ff;
      rep_long_in    = rep_long_ff;
      cnt_zero_in    = cnt_zero_ff;
      divisor_in     = divisor_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop = 1'b1;
               if (q_head.press) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_PRESS;
                  rsp_last_in    = !q_head.report;
                  rsp_press_in   = dur_ext[PRESS_WIDTH-1:0];
                  rsp_is_long_in = q_head.is_long;
                  rsp_total_in   = '0;
                  rsp_short_in   = '0;
                  rsp_long_in    = '0;
                  rsp_avg_in     = '0;
                  if (q_head.is_long) begin
                     if (long_count_ff != '1) begin
                        long_count_in = long_count_ff + COUNT_WIDTH'(1);
                     end
                     long_sum_in = long_acc[SUM_WIDTH] ? '1 : long_acc[SUM_WIDTH-1:0];
                  end else begin
                     if (short_count_ff != '1) begin
                        short_count_in = short_count_ff + COUNT_WIDTH'(1);
                     end
                     short_sum_in = short_acc[SUM_WIDTH] ? '1 : short_acc[SUM_WIDTH-1:0];
                  end
               end
               if (q_head.report) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            // snapshot the period, clear it and start the divider
            rep_total_in   = sat_field(64'(cnt_sat));
            rep_short_in   = sat_field(64'(short_count_ff));
            rep_long_in    = sat_field(64'(long_count_ff));
            cnt_zero_in    = cnt_all == '0;
            divisor_in     = cnt_all;
            quo_in         = sum_all;
            rem_in         = '0;
            step_in        = STEP_WIDTH'(DIVIDEND_WIDTH);
            short_count_in = '0;
            long_count_in  = '0;
            short_sum_in   = '0;
            long_sum_in    = '0;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (rem_sh >= REM_WIDTH'(divisor_ff)) begin
               rem_in = rem_sh - REM_WIDTH'(divisor_ff);
               quo_in = quo_sh | DIVIDEND_WIDTH'(1);
            end else begin
               rem_in = rem_sh;
               quo_in = quo_sh;
            end
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_REPORT;
               rsp_last_in    = 1'b1;
               rsp_press_in   = '0;
               rsp_is_long_in = 1'b0;
               rsp_total_in   = rep_total_ff;
               rsp_short_in   = rep_short_ff;
               rsp_long_in    = rep_long_ff;
               rsp_avg_in     = cnt_zero_ff ? '0 : sat_word(64'(quo_ff));
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         short_count_ff <= '0;
         long_count_ff  <= '0;
         short_sum_ff   <= '0;
         long_sum_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         short_count_ff <= short_count_in;
         long_count_ff  <= long_count_in;
         short_sum_ff   <= short_sum_in;
         long_sum_ff    <= long_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_press_ff   <= rsp_press_in;
      rsp_is_long_ff <= rsp_is_long_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_short_ff   <= rsp_short_in;
      rsp_long_ff    <= rsp_long_in;
      rsp_avg_ff     <= rsp_avg_in;
      rep_total_ff   <= rep_total_in;
      rep_short_ff   <= rep_short_in;
      rep_long_ff    <= rep_long_in;
      cnt_zero_ff    <= cnt_zero_in;
      divisor_ff     <= divisor_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_WIDTH{1'b0}}, rsp_avg_ff, rsp_long_ff, rsp_short_ff,
                        rsp_total_ff, rsp_is_long_ff, rsp_press_ff};

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> out_free)
      else $error("command popped while result register is occupied");

   a_div_steps_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff != '0))
      else $error("divider running with no steps left");

   a_setup_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETUP) |=> (short_count_ff == '0 && long_count_ff == '0 &&
                                  short_sum_ff == '0 && long_sum_ff == '0))
      else $error("statistics not cleared after report snapshot");

   a_report_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=>
         (rsp_valid_ff && rsp_kind_ff == KIND_REPORT && rsp_last_ff))
      else $error("report not presented as final word");

   a_press_only_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.press && !q_head.report) |=>
         (rsp_valid_ff && rsp_kind_ff == KIND_PRESS && rsp_last_ff))
      else $error("lone press result not marked last");

endmodule

>>> src/button_press_duration_stats_core.sv
// Button press duration statistics: one tick per input word, press results
// and periodic reports out. Depends on bpds_pkg, bpds_front, bpds_queue, bpds_back.
//
// Usage:
//   req_* carries one word per millisecond tick, req_tdata[0] = button level
//   (1 released, 0 pressed). rsp_* carries result words: rsp_tuser is the
//   kind (0 press result, 1 statistics report), rsp_tlast marks the final
//   word caused by a tick. csr_* writes the long-press threshold (index 0,
//   ms) and the report interval (index 1, seconds) while the block is idle.
//   Timing: the front takes one tick per cycle while the four-entry command
//   queue has room. A press result passes through the command queue and then
//   the output register. A report occupies the back part through pop,
//   snapshot, 33 steps of the serial divider for the average and load; it
//   pops no new command meanwhile. Ticks without results are not queued.
//   Reset (synchronous, active high) clears the clock, edge state, counts,
//   sums and queue and restores the register defaults (500 ms, 10 s).
//   A stalled rsp_tready holds the result word; the back part stops popping
//   and, once the queue fills, req_tready drops.
module button_press_duration_stats_core import bpds_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] button_up, [7:1] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [31:0] press_ms, [32] is_long, [48:33] total_presses, [64:49] short_presses,
   // [80:65] long_presses, [112:81] average_ms, [119:113] zero
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                       rsp_tuser,   // [0] kind
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   q_status_type q_status;
   logic         q_push;
   cmd_type      q_push_cmd;
   logic         q_pop;
   cmd_type      q_head;

   bpds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_push_cmd (q_push_cmd)
   );

   bpds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   bpds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/tb.sv
// Self-checking bench for button_press_duration_stats_core: millisecond ticks in,
// press results and periodic reports checked against an in-bench scoreboard model.
// Depends on bpds_pkg and the core RTL only.
module tb;
   import bpds_pkg::*;

   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic                   kind;
      logic [PRESS_WIDTH-1:0] press_ms;
      logic                   is_long;
      logic [FIELD_WIDTH-1:0] total;
      logic [FIELD_WIDTH-1:0] shorts;
      logic [FIELD_WIDTH-1:0] longs;
      logic [AVG_WIDTH-1:0]   avg_ms;
      logic                   last;
   } result_type;

   typedef enum logic [0:0] {ROW_TICK, ROW_WRITE} row_op_type;

   typedef struct packed {
      row_op_type                 op;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [CSR_DATA_WIDTH-1:0]  reg_value;
      logic                       level;
      logic                       typed;
      result_type                 want;
   } script_row_type;

   localparam result_type NO_RESULT = '0;
   localparam result_type ONE_MS_PRESS =
      '{KIND_PRESS, 32'd1, 1'b0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1};
   localparam result_type EMPTY_REPORT =
      '{KIND_REPORT, 32'd0, 1'b0, 16'd0, 16'd0, 16'd0, 32'd0, 1'b1};

   localparam int NUM_ROWS = 28;
   script_row_type directed_script [0:NUM_ROWS-1] = '{
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b1, ONE_MS_PRESS},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      // zero interval: a report on every tick
      '{ROW_WRITE, CSR_REPORT_INTERVAL_S, 16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b1, EMPTY_REPORT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      // zero threshold: every press is long
      '{ROW_WRITE, CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_LONG_PRESS_MS,     16'hFFFF,  1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      // threshold right at the shortest possible press
      '{ROW_WRITE, CSR_LONG_PRESS_MS,     16'd1,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_REPORT_INTERVAL_S, 16'h0FFF,  1'b0, 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_REPORT_INTERVAL_S, 16'd3600,  1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b0, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT},
      '{ROW_TICK,  CSR_LONG_PRESS_MS,     16'd0,     1'b1, 1'b0, NO_RESULT}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   button_press_duration_stats_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scoreboard copy of the block state and registers
   logic [LONG_WIDTH-1:0]     long_thresh    = LONG_WIDTH'(LONG_RESET);
   logic [INTERVAL_WIDTH-1:0] report_every_s = INTERVAL_WIDTH'(INTERVAL_RESET);
   logic                      level_seen     = 1'b1;
   logic [TIME_WIDTH-1:0]     tick_ms        = '0;
   logic [TIME_WIDTH-1:0]     press_began_ms = '0;
   logic [TIME_WIDTH-1:0]     report_base_ms = '0;
   logic [COUNT_WIDTH-1:0]    n_short        = '0;
   logic [COUNT_WIDTH-1:0]    n_long         = '0;
   logic [SUM_WIDTH-1:0]      ms_short       = '0;
   logic [SUM_WIDTH-1:0]      ms_long        = '0;

   result_type tick_results [$];
   result_type due_results [$];

   int   errors = 0;
   int   quiet_cycles = 0;
   logic sender_calm = 1'b0;
   logic receiver_calm = 1'b0;
   logic hold_output = 1'b0;

   // Work out the result words one tick causes and advance the clock
   function automatic void tally_tick(input logic level);
      logic [TIME_WIDTH-1:0] t;
      logic [TIME_WIDTH-1:0] dur;
      logic [TIME_WIDTH-1:0] elapsed;
      logic [63:0]           wide;
      logic [63:0]           cnt;
      logic [63:0]           avg;
      result_type            r;
      t = tick_ms;
      if (level != level_seen) begin
         if (level) begin
            dur = t - press_began_ms;
            r = '0;
            r.kind = KIND_PRESS;
            r.press_ms = dur;
            r.is_long = (dur >= {16'd0, long_thresh});
            if (r.is_long) begin
               if (n_long != '1) n_long = n_long + 1'b1;
               wide = {32'd0, ms_long} + {32'd0, dur};
               ms_long = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
            end else begin
               if (n_short != '1) n_short = n_short + 1'b1;
               wide = {32'd0, ms_short} + {32'd0, dur};
               ms_short = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
            end
            tick_results.push_back(r);
         end else begin
            press_began_ms = t;
         end
         level_seen = level;
      end
      elapsed = t - report_base_ms;
      if (elapsed / MS_PER_S >= {20'd0, report_every_s}) begin
         cnt = {48'd0, n_short} + {48'd0, n_long};
         wide = {32'd0, ms_short} + {32'd0, ms_long};
         avg = (cnt == 0) ? 64'd0 : wide / cnt;
         r = '0;
         r.kind = KIND_REPORT;
         r.total = (cnt > 64'hFFFF) ? '1 : cnt[15:0];
         r.shorts = n_short;
         r.longs = n_long;
         r.avg_ms = (avg > 64'hFFFF_FFFF) ? '1 : avg[31:0];
         tick_results.push_back(r);
         report_base_ms = t;
         n_short = '0;
         n_long = '0;
         ms_short = '0;
         ms_long = '0;
      end
      if (tick_results.size() != 0) tick_results[tick_results.size() - 1].last = 1'b1;
      tick_ms = t + 1'b1;
   endfunction

   // Offer one tick word; return at the edge where it is taken, valid still high
   task automatic send_tick(input logic level, input logic typed, input result_type want);
      int         gap;
      result_type r;
      if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tally_tick(level);
      while (tick_results.size() != 0) begin
         r = tick_results.pop_front();
         if (!typed) due_results.push_back(r);
      end
      if (typed) due_results.push_back(want);
      req_tdata <= {{(REQ_DATA_WIDTH-1){1'b0}}, level};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and hold until every expected word is out, then settle
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      wait_idle(SETTLE_CYCLES);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_LONG_PRESS_MS) long_thresh = value;
      else report_every_s = value[INTERVAL_WIDTH-1:0];
   endtask

   // Mostly press/release runs of random length, with some single noise ticks
   task automatic stir_presses(input int n_ticks, input int max_len,
                               input int hold_at, input int pause_at);
      int sent;
      int k;
      sent = 0;
      while (sent < n_ticks) begin
         if (hold_at >= 0 && sent >= hold_at) begin
            hold_output = 1'b1;
            hold_at = -1;
         end
         if (pause_at >= 0 && sent >= pause_at) begin
            wait_idle(0);
            pause_at = -1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_tick(1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
            sent++;
         end else begin
            k = $urandom_range(1, max_len);
            repeat (k) send_tick(1'b0, 1'b0, NO_RESULT);
            sent += k;
            k = $urandom_range(1, max_len);
            repeat (k) send_tick(1'b1, 1'b0, NO_RESULT);
            sent += k;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind     = rsp_tuser;
         seen.press_ms = rsp_tdata[31:0];
         seen.is_long  = rsp_tdata[32];
         seen.total    = rsp_tdata[48:33];
         seen.shorts   = rsp_tdata[64:49];
         seen.longs    = rsp_tdata[80:65];
         seen.avg_ms   = rsp_tdata[112:81];
         seen.last     = rsp_tlast;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, seen);
            errors++;
         end else begin
            want = due_results.pop_front();
            check_field("kind", 32'(want.kind), 32'(seen.kind));
            check_field("press_ms", want.press_ms, seen.press_ms);
            check_field("is_long", 32'(want.is_long), 32'(seen.is_long));
            check_field("total_presses", 32'(want.total), 32'(seen.total));
            check_field("short_presses", 32'(want.shorts), 32'(seen.shorts));
            check_field("long_presses", 32'(want.longs), 32'(seen.longs));
            check_field("average_ms", want.avg_ms, seen.avg_ms);
            check_field("last", 32'(want.last), 32'(seen.last));
         end
      end
   end

   // Result side: random stall per word, one long hold-off on request
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         stall = receiver_calm ? 0 : $urandom_range(0, 8);
         if (hold_output) begin
            stall = HOLD_CYCLES;
            hold_output = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("button_press_duration_stats_core verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         if (directed_script[i].op == ROW_WRITE)
            write_reg(directed_script[i].reg_index, directed_script[i].reg_value);
         else
            send_tick(directed_script[i].level, directed_script[i].typed,
                      directed_script[i].want);
      end

      // Report on every tick; hold the output long enough to back up the input
      write_reg(CSR_LONG_PRESS_MS, 16'($urandom_range(0, 6)));
      write_reg(CSR_REPORT_INTERVAL_S, 16'd0);
      stir_presses(80, 8, 30, -1);

      // One-second interval: the run is long enough for a report to fall due
      write_reg(CSR_LONG_PRESS_MS, 16'($urandom_range(1, 40)));
      write_reg(CSR_REPORT_INTERVAL_S, 16'd1);
      stir_presses(1000, 50, -1, 400);

      write_reg(CSR_LONG_PRESS_MS, 16'($urandom_range(0, 16'hFFFF)));
      write_reg(CSR_REPORT_INTERVAL_S, 16'd0);
      stir_presses(30, 10, -1, -1);

      wait_idle(SETTLE_CYCLES);
      if (errors == 0)
         $display("button_press_duration_stats_core verification clean");
      else
         $display("button_press_duration_stats_core verification failed");
      $finish;
   end

endmodule
